/* hdl/trop_pkg.sv */
`default_nettype none

package trop_pkg;

   localparam int TERM_CHARS        = 8;
   localparam int QUEUE_DEPTH       = 4;
   localparam int QUEUE_PTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_INDEX_WIDTH   = 3;
   localparam int CSR_DATA_WIDTH    = 64;

   typedef logic [7:0]                   byte_type;
   typedef logic [2:0]                   kind_type;
   typedef logic [3:0]                   count_type;
   typedef logic [CSR_INDEX_WIDTH-1:0]   csr_index_type;
   typedef logic [CSR_DATA_WIDTH-1:0]    csr_data_type;
   typedef logic [1:0]                   op_type;

   localparam byte_type B_IAC  = 8'd255;
   localparam byte_type B_DONT = 8'd254;
   localparam byte_type B_DO   = 8'd253;
   localparam byte_type B_WONT = 8'd252;
   localparam byte_type B_WILL = 8'd251;
   localparam byte_type B_SB   = 8'd250;
   localparam byte_type B_BRK  = 8'd243;
   localparam byte_type B_SE   = 8'd240;

   localparam byte_type OPT_BINARY  = 8'd0;
   localparam byte_type OPT_ECHO    = 8'd1;
   localparam byte_type OPT_SGA     = 8'd3;
   localparam byte_type OPT_TERM    = 8'd24;
   localparam byte_type OPT_COMPORT = 8'd44;

   localparam byte_type SUB_IS   = 8'd0;
   localparam byte_type SUB_SEND = 8'd1;

   localparam byte_type CP_SET_CONTROL = 8'd5;
   localparam byte_type CTL_DTR_ON     = 8'd8;
   localparam byte_type CTL_DTR_OFF    = 8'd9;
   localparam byte_type CTL_RTS_ON     = 8'd11;
   localparam byte_type CTL_RTS_OFF    = 8'd12;
   localparam byte_type CR_BYTE        = 8'd13;
   localparam byte_type NUL_BYTE       = 8'd0;

   localparam kind_type K_DATA  = 3'd0;
   localparam kind_type K_REPLY = 3'd1;
   localparam kind_type K_DTR   = 3'd2;
   localparam kind_type K_RTS   = 3'd3;
   localparam kind_type K_BREAK = 3'd4;

   localparam csr_index_type CSR_SENT_WILL_BINARY     = 3'd0;
   localparam csr_index_type CSR_SENT_WILL_ECHO       = 3'd1;
   localparam csr_index_type CSR_SENT_DO_BINARY       = 3'd2;
   localparam csr_index_type CSR_SENT_DO_ECHO         = 3'd3;
   localparam csr_index_type CSR_TERMINAL_NAME        = 3'd4;
   localparam csr_index_type CSR_TERMINAL_NAME_LENGTH = 3'd5;
   localparam csr_index_type CSR_LINE_CONTROL_ENABLE  = 3'd6;

   localparam op_type CMD_SINGLE = 2'd0;
   localparam op_type CMD_REPLY3 = 2'd1;
   localparam op_type CMD_TERM   = 2'd2;

   typedef struct packed {
      logic         sent_will_binary;
      logic         sent_will_echo;
      logic         sent_do_binary;
      logic         sent_do_echo;
      csr_data_type terminal_name;
      count_type    terminal_name_length;
      logic         line_control_enable;
   } cfg_type;

   typedef struct packed {
      op_type   op;
      kind_type kind;
      byte_type b0;
      byte_type b1;
   } cmd_type;

endpackage

`default_nettype wire

/* hdl/trop_if.sv */
`default_nettype none

interface trop_req_if;
   import trop_pkg::*;
   logic     valid;
   logic     ready;
   byte_type rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface trop_rsp_if;
   import trop_pkg::*;
   logic     valid;
   logic     ready;
   kind_type kind;
   byte_type byte_value;
   logic     last;
   modport source (output valid, output kind, output byte_value, output last, input ready);
   modport sink (input valid, input kind, input byte_value, input last, output ready);
endinterface

interface trop_csr_if;
   import trop_pkg::*;
   logic          valid;
   logic          ready;
   csr_index_type index;
   csr_data_type  data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hdl/trop_csr.sv */
`default_nettype none

module trop_csr (
   input  wire               clock,
   input  wire               reset,
   trop_csr_if.sink          csr_bus,
   output trop_pkg::cfg_type cfg
);
   import trop_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_SENT_WILL_BINARY:     cfg_in.sent_will_binary = csr_bus.data[0];
            CSR_SENT_WILL_ECHO:       cfg_in.sent_will_echo = csr_bus.data[0];
            CSR_SENT_DO_BINARY:       cfg_in.sent_do_binary = csr_bus.data[0];
            CSR_SENT_DO_ECHO:         cfg_in.sent_do_echo = csr_bus.data[0];
            CSR_TERMINAL_NAME:        cfg_in.terminal_name = csr_bus.data;
            CSR_TERMINAL_NAME_LENGTH: cfg_in.terminal_name_length = csr_bus.data[3:0];
            CSR_LINE_CONTROL_ENABLE:  cfg_in.line_control_enable = csr_bus.data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sent_will_binary     <= 1'b1;
         cfg_ff.sent_will_echo       <= 1'b1;
         cfg_ff.sent_do_binary       <= 1'b1;
         cfg_ff.sent_do_echo         <= 1'b1;
         cfg_ff.terminal_name        <= '0;
         cfg_ff.terminal_name_length <= '0;
         cfg_ff.line_control_enable  <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/trop_front.sv */
`default_nettype none

module trop_front (
   input  wire               clock,
   input  wire               reset,
   trop_req_if.sink          req_bus,
   input  trop_pkg::cfg_type cfg,
   input  wire               queue_full,
   output logic              push,
   output trop_pkg::cmd_type push_cmd
);
   import trop_pkg::*;

   localparam logic [3:0] PH_DATA       = 4'd0;
   localparam logic [3:0] PH_IAC        = 4'd1;
   localparam logic [3:0] PH_WILL       = 4'd2;
   localparam logic [3:0] PH_DO         = 4'd3;
   localparam logic [3:0] PH_WONT       = 4'd4;
   localparam logic [3:0] PH_SB         = 4'd5;
   localparam logic [3:0] PH_SB_TERM    = 4'd6;
   localparam logic [3:0] PH_SB_COMPORT = 4'd7;
   localparam logic [3:0] PH_SB_SKIP    = 4'd8;
   localparam logic [3:0] PH_SB_IAC     = 4'd9;

   logic [3:0] phase_ff, phase_in;
   logic       crlf_ff, crlf_in;
   logic       rx_binary_ff, rx_binary_in;
   logic       term_query_ff, term_query_in;
   logic       ctl_pending_ff, ctl_pending_in;
   byte_type   ctl_value_ff, ctl_value_in;
   logic       accept;
   byte_type   ch;

   assign req_bus.ready = !queue_full;
   assign accept = req_bus.valid && !queue_full;
   assign ch = req_bus.rx_byte;

   always_comb begin
      phase_in       = phase_ff;
      crlf_in        = crlf_ff;
      rx_binary_in   = rx_binary_ff;
      term_query_in  = term_query_ff;
      ctl_pending_in = ctl_pending_ff;
      ctl_value_in   = ctl_value_ff;
      push           = 1'b0;
      push_cmd       = '0;
      if (accept) begin
         crlf_in = 1'b0;
         if (!(crlf_ff && ch == NUL_BYTE)) begin
            case (phase_ff)
               PH_DATA: begin
                  if (ch == B_IAC) begin
                     phase_in = PH_IAC;
                  end else begin
                     push          = 1'b1;
                     push_cmd.op   = CMD_SINGLE;
                     push_cmd.kind = K_DATA;
                     push_cmd.b0   = ch;
                     if (ch == CR_BYTE && !rx_binary_ff) crlf_in = 1'b1;
                  end
               end
               PH_IAC: begin
                  phase_in = PH_DATA;
                  if (ch == B_IAC) begin
                     push          = 1'b1;
                     push_cmd.op   = CMD_SINGLE;
                     push_cmd.kind = K_DATA;
                     push_cmd.b0   = ch;
                  end else if (ch == B_SB) begin
                     phase_in = PH_SB;
                  end else if (ch == B_WILL) begin
                     phase_in = PH_WILL;
                  end else if (ch == B_DO) begin
                     phase_in = PH_DO;
                  end else if (ch inside {B_DONT, B_WONT}) begin
                     phase_in = PH_WONT;
                  end else if (ch == B_BRK) begin
                     push          = 1'b1;
                     push_cmd.op   = CMD_SINGLE;
                     push_cmd.kind = K_BREAK;
                  end
               end
               PH_WONT: phase_in = PH_DATA;
               PH_DO: begin
                  phase_in    = PH_DATA;
                  push_cmd.op = CMD_REPLY3;
                  push_cmd.b1 = ch;
                  if (ch == OPT_BINARY) begin
                     push        = !cfg.sent_will_binary;
                     push_cmd.b0 = B_WILL;
                  end else if (ch == OPT_ECHO) begin
                     push        = !cfg.sent_will_echo;
                     push_cmd.b0 = B_WONT;
                  end else begin
                     push        = !(ch inside {OPT_SGA, OPT_TERM});
                     push_cmd.b0 = B_WONT;
                  end
               end
               PH_WILL: begin
                  phase_in    = PH_DATA;
                  push_cmd.op = CMD_REPLY3;
                  push_cmd.b1 = ch;
                  if (ch == OPT_BINARY) begin
                     rx_binary_in = 1'b1;
                     push         = !cfg.sent_do_binary;
                     push_cmd.b0  = B_DO;
                  end else if (ch == OPT_ECHO) begin
                     push        = !cfg.sent_do_echo;
                     push_cmd.b0 = B_DO;
                  end else begin
                     push        = !(ch inside {OPT_SGA, OPT_TERM});
                     push_cmd.b0 = B_DONT;
                  end
               end
               PH_SB: begin
                  if (ch == OPT_COMPORT)   phase_in = PH_SB_COMPORT;
                  else if (ch == OPT_TERM) phase_in = PH_SB_TERM;
                  else                     phase_in = PH_SB_SKIP;
               end
               PH_SB_TERM: begin
                  if (ch == SUB_SEND) term_query_in = 1'b1;
                  phase_in = PH_SB_SKIP;
               end
               PH_SB_COMPORT: begin
                  if (ctl_pending_ff) begin
                     ctl_value_in = ch;
                     phase_in     = PH_SB_SKIP;
                  end else if (ch == CP_SET_CONTROL) begin
                     ctl_pending_in = 1'b1;
                  end else begin
                     phase_in = PH_SB_SKIP;
                  end
               end
               PH_SB_SKIP: begin
                  if (ch == B_IAC) phase_in = PH_SB_IAC;
               end
               PH_SB_IAC: begin
                  if (ch != B_SE) begin
                     phase_in = PH_SB_SKIP;
                  end else begin
                     if (term_query_ff) begin
                        push        = 1'b1;
                        push_cmd.op = CMD_TERM;
                     end else if (ctl_pending_ff && cfg.line_control_enable) begin
                        push_cmd.op = CMD_SINGLE;
                        case (ctl_value_ff)
                           CTL_DTR_ON: begin
                              push          = 1'b1;
                              push_cmd.kind = K_DTR;
                              push_cmd.b0   = 8'd1;
                           end
                           CTL_DTR_OFF: begin
                              push          = 1'b1;
                              push_cmd.kind = K_DTR;
                           end
                           CTL_RTS_ON: begin
                              push          = 1'b1;
                              push_cmd.kind = K_RTS;
                              push_cmd.b0   = 8'd1;
                           end
                           CTL_RTS_OFF: begin
                              push          = 1'b1;
                              push_cmd.kind = K_RTS;
                           end
                           default: ;
                        endcase
                     end
                     term_query_in  = 1'b0;
                     ctl_pending_in = 1'b0;
                     phase_in       = PH_DATA;
                  end
               end
               default: phase_in = PH_DATA;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_DATA;
         crlf_ff        <= 1'b0;
         rx_binary_ff   <= 1'b0;
         term_query_ff  <= 1'b0;
         ctl_pending_ff <= 1'b0;
         ctl_value_ff   <= '0;
      end else begin
         phase_ff       <= phase_in;
         crlf_ff        <= crlf_in;
         rx_binary_ff   <= rx_binary_in;
         term_query_ff  <= term_query_in;
         ctl_pending_ff <= ctl_pending_in;
         ctl_value_ff   <= ctl_value_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/trop_queue.sv */
`default_nettype none

module trop_queue (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  trop_pkg::cmd_type push_cmd,
   output logic              full,
   output logic              head_valid,
   output trop_pkg::cmd_type head_cmd,
   input  wire               pop
);
   import trop_pkg::*;

   cmd_type                       entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_WIDTH-1:0]  count_ff, count_in;

   localparam logic [QUEUE_COUNT_WIDTH-1:0] COUNT_FULL = QUEUE_COUNT_WIDTH'(QUEUE_DEPTH);
   localparam logic [QUEUE_PTR_WIDTH-1:0]   PTR_LAST   = QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1);

   assign full       = (count_ff == COUNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_FULL)
      else $error("queue count beyond depth");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

/* hdl/trop_back.sv */
`default_nettype none

module trop_back (
   input  wire               clock,
   input  wire               reset,
   input  trop_pkg::cfg_type cfg,
   input  wire               head_valid,
   input  trop_pkg::cmd_type head_cmd,
   output logic              pop,
   trop_rsp_if.source        rsp_bus
);
   import trop_pkg::*;

   localparam count_type TERM_MAX = count_type'(TERM_CHARS);

   count_type idx_ff, idx_in;
   logic      rsp_valid_ff, rsp_valid_in;
   kind_type  rsp_kind_ff, rsp_kind_in;
   byte_type  rsp_byte_ff, rsp_byte_in;
   logic      rsp_last_ff, rsp_last_in;

   count_type name_len;
   count_type last_idx;
   count_type name_sel;
   logic      slot_free;
   logic      emit;
   logic      at_last;
   byte_type  cur_byte;
   kind_type  cur_kind;

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.kind       = rsp_kind_ff;
   assign rsp_bus.byte_value = rsp_byte_ff;
   assign rsp_bus.last       = rsp_last_ff;

   assign name_len  = (cfg.terminal_name_length > TERM_MAX) ? TERM_MAX
                                                            : cfg.terminal_name_length;
   assign name_sel  = idx_ff - 4'd4;
   assign slot_free = !rsp_valid_ff || rsp_bus.ready;
   assign emit      = head_valid && slot_free;
   assign at_last   = (idx_ff == last_idx);
   assign pop       = emit && at_last;

   always_comb begin
      last_idx = '0;
      cur_kind = K_REPLY;
      cur_byte = '0;
      case (head_cmd.op)
         CMD_SINGLE: begin
            cur_kind = head_cmd.kind;
            cur_byte = head_cmd.b0;
         end
         CMD_REPLY3: begin
            last_idx = 4'd2;
            case (idx_ff)
               4'd0:    cur_byte = B_IAC;
               4'd1:    cur_byte = head_cmd.b0;
               default: cur_byte = head_cmd.b1;
            endcase
         end
         CMD_TERM: begin
            last_idx = name_len + 4'd5;
            if (idx_ff == 4'd0)                 cur_byte = B_IAC;
            else if (idx_ff == 4'd1)            cur_byte = B_SB;
            else if (idx_ff == 4'd2)            cur_byte = OPT_TERM;
            else if (idx_ff == 4'd3)            cur_byte = SUB_IS;
            else if (idx_ff == last_idx)        cur_byte = B_SE;
            else if (idx_ff == last_idx - 4'd1) cur_byte = B_IAC;
            else cur_byte = cfg.terminal_name[{name_sel[2:0], 3'b000} +: 8];
         end
         default: ;
      endcase
   end

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = cur_kind;
         rsp_byte_in  = cur_byte;
         rsp_last_in  = at_last;
         idx_in       = at_last ? '0 : idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_pop_marks_last: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid_ff && rsp_last_ff)
      else $error("command retired without final result");
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> idx_ff <= last_idx)
      else $error("result index past end of command");
   a_idx_idle_zero: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> idx_ff == '0)
      else $error("result index not cleared while queue empty");
`endif

endmodule

`default_nettype wire

/* hdl/telnet_receive_option_parser_unit.sv */
`default_nettype none
// A parsed command enters the queue; its first result is then registered at the output.
// Throughput: one byte per cycle; a command with several results sends one per cycle
// from the back end while the response bus is ready; a 4-entry queue lets the front keep
// parsing, and input stalls only while the queue holds four commands.
// Reset: synchronous, active high; clears parser state and queue and restores
// configuration registers to their reset values.

module telnet_receive_option_parser_unit (
   input  wire        clock,
   input  wire        reset,
   trop_req_if.sink   req_bus,
   trop_rsp_if.source rsp_bus,
   trop_csr_if.sink   csr_bus
);
   import trop_pkg::*;

   cfg_type cfg;
   logic    push;
   cmd_type push_cmd;
   logic    queue_full;
   logic    head_valid;
   cmd_type head_cmd;
   logic    pop;

   trop_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   trop_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .cfg        (cfg),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   trop_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop)
   );

   trop_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

endmodule

`default_nettype wire
